[hw/rtl/u16u8_pkg.sv]
`timescale 1ns / 1ps

package u16u8_pkg;

  // Surrogate range bounds and the offsets used to join a pair.
  localparam logic [15:0] SURR_LO      = 16'hD800;
  localparam logic [15:0] SURR_HI      = 16'hDFFF;
  localparam logic [15:0] TRAIL_BASE   = 16'hDC00;
  localparam logic [20:0] SUPPL_BASE   = 21'h10000;

  // Byte order mark bytes.
  localparam logic [7:0]  MARK_FF      = 8'hFF;
  localparam logic [7:0]  MARK_FE      = 8'hFE;

  // UTF-8 lead and continuation prefixes.
  localparam logic [7:0]  LEAD2        = 8'hC0;
  localparam logic [7:0]  LEAD3        = 8'hE0;
  localparam logic [7:0]  LEAD4        = 8'hF0;
  localparam logic [7:0]  CONT         = 8'h80;

  // Number of bytes one input byte may give.
  localparam int          MAX_BYTES    = 4;

  typedef logic [2:0] byte_cnt_t;

  // One encoded group of UTF-8 bytes, first byte in slot 0.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    byte_cnt_t                 count;
  } enc_entry_t;

endpackage

[hw/rtl/u16u8_front.sv]
`timescale 1ns / 1ps

module u16u8_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_string_start,
  input  logic                  q_full,
  output logic                  q_push,
  output u16u8_pkg::enc_entry_t q_push_entry
);
  import u16u8_pkg::*;

  logic        dflt_be_r;
  logic        be_r, be_nxt;
  logic        phase_r, phase_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [15:0] lead_r, lead_nxt;
  logic        await_r, await_nxt;
  logic        win_r, win_nxt;

  logic        accept;
  logic        phase_eff, await_eff, win_eff;
  logic [15:0] unit;
  logic [15:0] trail_x;
  logic [20:0] code;
  enc_entry_t  entry;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // A new string drops any partial unit or pair and reopens the mark window.
  assign phase_eff = in_string_start ? 1'b0 : phase_r;
  assign await_eff = in_string_start ? 1'b0 : await_r;
  assign win_eff   = in_string_start ? 1'b1 : win_r;

  // Unit assembly, mark detection and classification of a completed unit.
  always_comb begin
    be_nxt      = be_r;
    phase_nxt   = phase_eff;
    held_nxt    = held_r;
    lead_nxt    = lead_r;
    await_nxt   = await_eff;
    win_nxt     = win_eff;
    unit        = 16'h0;
    trail_x     = 16'h0;
    code        = 21'h0;
    entry.bytes = '0;
    entry.count = '0;
    if (!phase_eff) begin
      held_nxt  = in_data_byte;
      phase_nxt = 1'b1;
    end else begin
      phase_nxt = 1'b0;
      if (win_eff) begin
        win_nxt = 1'b0;
        if (held_r == MARK_FF && in_data_byte == MARK_FE) begin
          be_nxt = 1'b0;
        end else if (held_r == MARK_FE && in_data_byte == MARK_FF) begin
          be_nxt = 1'b1;
        end else begin
          be_nxt = dflt_be_r;
        end
      end
      unit    = be_nxt ? {held_r, in_data_byte} : {in_data_byte, held_r};
      // Code point of a surrogate pair; only bits 20..0 are kept.
      trail_x = unit ^ TRAIL_BASE;
      code    = SUPPL_BASE + {lead_r[10:0] ^ SURR_LO[10:0], 10'b0} + {5'b0, trail_x};
      if (win_eff && ((held_r == MARK_FF && in_data_byte == MARK_FE) ||
                      (held_r == MARK_FE && in_data_byte == MARK_FF))) begin
        // The mark itself gives no output.
        entry.count = '0;
      end else if (await_eff) begin
        await_nxt      = 1'b0;
        entry.bytes[0] = LEAD4 | {5'b0, code[20:18]};
        entry.bytes[1] = CONT | {2'b0, code[17:12]};
        entry.bytes[2] = CONT | {2'b0, code[11:6]};
        entry.bytes[3] = CONT | {2'b0, code[5:0]};
        entry.count    = 3'd4;
      end else if (unit >= SURR_LO && unit <= SURR_HI) begin
        lead_nxt  = unit;
        await_nxt = 1'b1;
      end else if (unit < 16'h0080) begin
        entry.bytes[0] = unit[7:0];
        entry.count    = 3'd1;
      end else if (unit < 16'h0800) begin
        entry.bytes[0] = LEAD2 | {3'b0, unit[10:6]};
        entry.bytes[1] = CONT | {2'b0, unit[5:0]};
        entry.count    = 3'd2;
      end else begin
        entry.bytes[0] = LEAD3 | {4'b0, unit[15:12]};
        entry.bytes[1] = CONT | {2'b0, unit[11:6]};
        entry.bytes[2] = CONT | {2'b0, unit[5:0]};
        entry.count    = 3'd3;
      end
    end
  end

  assign q_push       = accept && (entry.count != '0);
  assign q_push_entry = entry;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_be_r <= 1'b1;
    end else if (cfg_wr_en) begin
      dflt_be_r <= cfg_wr_data;
    end
  end

  // Stream state, updated on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      be_r    <= 1'b1;
      phase_r <= 1'b0;
      held_r  <= 8'h0;
      lead_r  <= 16'h0;
      await_r <= 1'b0;
      win_r   <= 1'b1;
    end else if (accept) begin
      be_r    <= be_nxt;
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      lead_r  <= lead_nxt;
      await_r <= await_nxt;
      win_r   <= win_nxt;
    end
  end

endmodule

[hw/rtl/u16u8_queue.sv]
`timescale 1ns / 1ps

module u16u8_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  u16u8_pkg::enc_entry_t push_entry,
  input  logic                  pop,
  output logic                  full,
  output logic                  not_empty,
  output u16u8_pkg::enc_entry_t head
);
  import u16u8_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  enc_entry_t     slots_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  fill_r, fill_nxt;
  logic           do_push, do_pop;

  assign full      = (fill_r == CW'(DEPTH));
  assign not_empty = (fill_r != '0);
  assign head      = slots_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Pointer wrap and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CW'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[hw/rtl/u16u8_back.sv]
`timescale 1ns / 1ps

module u16u8_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_not_empty,
  input  u16u8_pkg::enc_entry_t q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_utf8_byte,
  output logic                  out_run_last
);
  import u16u8_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load;
  logic       is_last;

  // The output register takes a new byte when it is empty or being transferred.
  assign load    = q_not_empty && (!out_valid_r || !out_stall);
  assign is_last = ({1'b0, idx_r} == q_head.count - 3'd1);
  assign q_pop   = load && is_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = is_last ? 2'd0 : idx_r + 2'd1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= q_head.bytes[idx_r];
      last_r <= is_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_utf8_byte = byte_r;
  assign out_run_last  = last_r;

endmodule

[hw/rtl/utf16_to_utf8_stream.sv]
// The first UTF-8 byte of a unit is written to the queue and then to the output
// register after the input byte that completes the unit is transferred; its other
// bytes follow one per cycle while out_stall is low. The input takes one byte per
// cycle while the queue has room; a unit gives up to three bytes and a pair four, so
// the output side sets the sustained rate.
// Reset (rst_n, synchronous, active low) empties the queue and output register.
`timescale 1ns / 1ps

module utf16_to_utf8_stream #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_string_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_utf8_byte,
  output logic       out_run_last
);
  import u16u8_pkg::*;

  logic       q_full, q_push, q_pop, q_not_empty;
  enc_entry_t q_push_entry, q_head;

  // Front end: unit assembly and encoding.
  u16u8_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_string_start (in_string_start),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_push_entry    (q_push_entry)
  );

  // Queue of encoded groups.
  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // Back end: byte serializer.
  u16u8_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_utf8_byte (out_utf8_byte),
    .out_run_last  (out_run_last)
  );

endmodule

[test/tb_utf16_to_utf8_stream.sv]
`timescale 1ns / 1ps

module tb_utf16_to_utf8_stream;

  import u16u8_pkg::*;

  // Cycles of quiet after the last result before a register write or the end.
  localparam int SETTLE_CYCLES = 10;
  localparam int TAIL_CYCLES   = 20;
  localparam int WATCHDOG_MAX  = 1000;
  // The receiver holds off once for this long, after this many transfers.
  localparam int LONG_HOLD     = 100;
  localparam int HOLD_AT_COUNT = 60;
  // Idling stops when this few entries are left to send.
  localparam int CALM_TAIL     = 40;

  typedef enum logic [1:0] {
    FEED_BYTE,
    FEED_SETTLE,
    FEED_CFG
  } feed_kind_t;

  typedef struct {
    feed_kind_t kind;
    logic [7:0] data;
    logic       start;
  } feed_t;

  typedef struct packed {
    logic [7:0] utf8;
    logic       last;
  } utf8_out_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_string_start = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_utf8_byte;
  logic       out_run_last;

  feed_t     feed_q[$];
  utf8_out_t utf8_expect[$];
  int        mismatch_count = 0;
  logic      calm = 1'b0;
  logic      next_start = 1'b0;
  int        fed_bytes = 0;

  // Transcoder state as the predictor tracks it.
  logic        dflt_be = 1'b1;
  logic        be_now = 1'b1;
  logic        phase = 1'b0;
  logic [7:0]  held = 8'h00;
  logic [15:0] lead = 16'h0000;
  logic        waiting = 1'b0;
  logic        window = 1'b1;

  utf16_to_utf8_stream dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_string_start(in_string_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_utf8_byte  (out_utf8_byte),
    .out_run_last   (out_run_last)
  );

  initial forever #10 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic push_utf8(input logic [7:0] b, input logic last);
    utf8_out_t item;
    item = '{utf8: b, last: last};
    utf8_expect.insert(utf8_expect.size(), item);
  endtask

  // Advance the transcoder by one accepted input byte and queue the UTF-8
  // bytes that it completes.
  task automatic encode_input_byte(input logic [7:0] b, input logic s);
    logic [7:0]  first;
    logic [15:0] unit;
    logic [31:0] sum;
    if (s) begin
      phase = 1'b0;
      waiting = 1'b0;
      window = 1'b1;
    end
    if (!phase) begin
      held = b;
      phase = 1'b1;
      return;
    end
    phase = 1'b0;
    first = held;

    // The first unit of a string is either a byte order mark or latches the default.
    if (window) begin
      window = 1'b0;
      if (first == MARK_FF && b == MARK_FE) begin
        be_now = 1'b0;
        return;
      end
      if (first == MARK_FE && b == MARK_FF) begin
        be_now = 1'b1;
        return;
      end
      be_now = dflt_be;
    end
    unit = be_now ? {first, b} : {b, first};

    if (waiting) begin
      // Any unit joins a held surrogate; only bits 20..0 of the sum are encoded.
      waiting = 1'b0;
      sum = 32'(SUPPL_BASE) + ({16'h0000, lead ^ SURR_LO} << 10)
          + {16'h0000, unit ^ TRAIL_BASE};
      push_utf8(LEAD4 | {5'b0, sum[20:18]}, 1'b0);
      push_utf8(CONT | {2'b0, sum[17:12]}, 1'b0);
      push_utf8(CONT | {2'b0, sum[11:6]}, 1'b0);
      push_utf8(CONT | {2'b0, sum[5:0]}, 1'b1);
    end else if (unit >= SURR_LO && unit <= SURR_HI) begin
      lead = unit;
      waiting = 1'b1;
    end else if (unit < 16'h0080) begin
      push_utf8(unit[7:0], 1'b1);
    end else if (unit < 16'h0800) begin
      push_utf8(LEAD2 | {3'b0, unit[10:6]}, 1'b0);
      push_utf8(CONT | {2'b0, unit[5:0]}, 1'b1);
    end else begin
      push_utf8(LEAD3 | {4'b0, unit[15:12]}, 1'b0);
      push_utf8(CONT | {2'b0, unit[11:6]}, 1'b0);
      push_utf8(CONT | {2'b0, unit[5:0]}, 1'b1);
    end
  endtask

  task automatic add_byte(input logic [7:0] b);
    feed_t item;
    item = '{kind: FEED_BYTE, data: b, start: next_start};
    feed_q.insert(feed_q.size(), item);
    next_start = 1'b0;
    fed_bytes++;
  endtask

  task automatic add_unit(input logic [15:0] u, input logic be);
    if (be) begin
      add_byte(u[15:8]);
      add_byte(u[7:0]);
    end else begin
      add_byte(u[7:0]);
      add_byte(u[15:8]);
    end
  endtask

  task automatic add_settle();
    feed_t item;
    item = '{kind: FEED_SETTLE, data: 8'h00, start: 1'b0};
    feed_q.insert(feed_q.size(), item);
  endtask

  task automatic add_cfg(input logic v);
    feed_t item;
    add_settle();
    item = '{kind: FEED_CFG, data: {7'b0, v}, start: 1'b0};
    feed_q.insert(feed_q.size(), item);
  endtask

  // One random string: mostly well-formed text, sometimes plain noise.
  task automatic gen_string(input logic cfg_be);
    logic        be;
    logic [15:0] u;
    next_start = 1'b1;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 9)) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    be = cfg_be;
    case ($urandom_range(0, 2))
      1: begin
        add_byte(MARK_FF);
        add_byte(MARK_FE);
        be = 1'b0;
      end
      2: begin
        add_byte(MARK_FE);
        add_byte(MARK_FF);
        be = 1'b1;
      end
      default: ;
    endcase
    repeat ($urandom_range(1, 10)) begin
      case ($urandom_range(0, 9))
        0, 1: add_unit(16'($urandom_range(0, 16'h007F)), be);
        2, 3: add_unit(16'($urandom_range(16'h0080, 16'h07FF)), be);
        4, 5: begin
          u = 16'($urandom_range(16'h0800, 16'hFFFF));
          if (u >= SURR_LO && u <= SURR_HI) u = u ^ 16'h2000;
          add_unit(u, be);
        end
        6, 7: begin
          add_unit(16'($urandom_range(SURR_LO, TRAIL_BASE - 1)), be);
          add_unit(16'($urandom_range(TRAIL_BASE, SURR_HI)), be);
        end
        8: begin
          add_unit(16'($urandom_range(SURR_LO, SURR_HI)), be);
          add_unit(16'($urandom_range(0, 16'hFFFF)), be);
        end
        default: add_unit(16'($urandom_range(0, 16'hFFFF)), be);
      endcase
    end
    // An odd byte left at the end is dropped by the next string start.
    if ($urandom_range(0, 4) == 0) add_byte(8'($urandom_range(0, 255)));
  endtask

  // Driver: presents queued bytes, applies register writes and waits out pauses.
  always @(posedge clk) begin : feed_driver
    logic  took;
    logic  nv;
    logic  wr;
    feed_t head;
    int    gap_left;
    int    settle_cnt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_wr_en <= 1'b0;
      gap_left = 0;
      settle_cnt = 0;
    end else begin
      took = in_valid && !in_stall;
      if (took) encode_input_byte(in_data_byte, in_string_start);
      nv = in_valid && !took;
      wr = 1'b0;
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (feed_q.size() != 0) begin
          head = feed_q[0];
          case (head.kind)
            FEED_BYTE: begin
              if (!calm && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 7);
              end else begin
                in_data_byte <= head.data;
                in_string_start <= head.start;
                nv = 1'b1;
                feed_q.delete(0);
              end
            end
            FEED_SETTLE: begin
              if (!took && utf8_expect.size() == 0) begin
                settle_cnt++;
                if (settle_cnt >= SETTLE_CYCLES) begin
                  settle_cnt = 0;
                  feed_q.delete(0);
                end
              end else begin
                settle_cnt = 0;
              end
            end
            FEED_CFG: begin
              wr = 1'b1;
              cfg_wr_data <= head.data[0];
              dflt_be = head.data[0];
              feed_q.delete(0);
            end
            default: feed_q.delete(0);
          endcase
        end
      end
      in_valid <= nv;
      cfg_wr_en <= wr;
      calm <= (feed_q.size() < CALM_TAIL);
    end
  end

  // Monitor: checks each output transfer and drives the receiver's stall.
  always @(posedge clk) begin : utf8_monitor
    utf8_out_t want;
    logic      ns;
    int        out_count;
    int        long_left;
    int        stall_left;
    logic      long_done;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_count = 0;
      long_left = 0;
      stall_left = 0;
      long_done = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_count++;
        if (utf8_expect.size() == 0) begin
          flag_mismatch($sformatf("unexpected byte %02h last %0b", out_utf8_byte,
                                  out_run_last));
        end else begin
          want = utf8_expect.pop_front();
          if (out_utf8_byte !== want.utf8)
            flag_mismatch($sformatf("utf8_byte %02h, expected %02h", out_utf8_byte,
                                    want.utf8));
          if (out_run_last !== want.last)
            flag_mismatch($sformatf("run_last %0b, expected %0b", out_run_last,
                                    want.last));
        end
      end
      if (long_left > 0) begin
        long_left--;
        ns = 1'b1;
      end else if (!long_done && out_count >= HOLD_AT_COUNT) begin
        long_done = 1'b1;
        long_left = LONG_HOLD - 1;
        ns = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        ns = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        ns = 1'b1;
      end else begin
        ns = 1'b0;
      end
      out_stall <= ns;
    end
  end

  // Watchdog: ends the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n) begin
      quiet = 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_MAX) begin
        $display("Timeout after %0d quiet cycles", quiet);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int phase_end;
    logic cfg_val;

    // Directed part, big-endian default.
    add_cfg(1'b1);
    next_start = 1'b1;
    add_byte(MARK_FE);
    add_byte(MARK_FF);
    add_unit(16'h0000, 1'b1);
    add_unit(16'h007F, 1'b1);
    add_unit(16'h0080, 1'b1);
    add_unit(16'h07FF, 1'b1);
    add_unit(16'h0800, 1'b1);
    add_unit(16'hFFFF, 1'b1);
    add_unit(16'hD83D, 1'b1);
    add_unit(16'hDE00, 1'b1);
    add_byte(8'h12);
    // Little-endian mark, a trail-range unit pairing with a lead, a mark-like
    // unit after the first one, and a lead cut off by a new string.
    next_start = 1'b1;
    add_byte(MARK_FF);
    add_byte(MARK_FE);
    add_unit(16'hDC00, 1'b0);
    add_unit(16'hD83D, 1'b0);
    add_unit(16'hFEFF, 1'b0);
    add_unit(16'hD800, 1'b0);
    // No mark: the big-endian default applies.
    next_start = 1'b1;
    add_unit(16'h4100, 1'b1);
    // No mark with the little-endian default.
    add_cfg(1'b0);
    next_start = 1'b1;
    add_unit(16'h0041, 1'b0);
    add_unit(16'h00E9, 1'b0);

    // Random phases over several register settings, each with a pause inside.
    for (int p = 0; p < 4; p++) begin
      cfg_val = (p == 3) ? 1'($urandom_range(0, 1)) : p[0];
      add_cfg(cfg_val);
      phase_end = fed_bytes + 85;
      while (fed_bytes < phase_end - 42) gen_string(cfg_val);
      add_settle();
      while (fed_bytes < phase_end) gen_string(cfg_val);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (feed_q.size() != 0 || in_valid || utf8_expect.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (utf8_expect.size() != 0)
      flag_mismatch($sformatf("%0d expected bytes never arrived", utf8_expect.size()));
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
